// ===== rtl/core/tswt_pkg.sv =====
// ----------------------------------------------------------------------------
// tswt_pkg
// shared types and constants of the send window tracker
// ----------------------------------------------------------------------------
package tswt_pkg;

  localparam int RingDepth = 16;
  localparam int TimeBits  = 48;
  localparam int PtrBits   = $clog2(RingDepth);
  localparam int CntBits   = $clog2(RingDepth + 1);
  localparam int QDepth    = 2;

  localparam logic [1:0] KindSend   = 2'd0;
  localparam logic [1:0] KindAck    = 2'd1;
  localparam logic [1:0] KindResend = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoRoom = 2'd1;
  localparam logic [1:0] StSeqErr = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegBase   = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [31:0]         seq_num;
    logic [15:0]         seg_length;
    logic [31:0]         ack_num;
    logic [TimeBits-1:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic [1:0]          send_status;
    logic                new_ack;
    logic                dup_ack;
    logic                fast_retransmit;
    logic                rtt_valid;
    logic [TimeBits-1:0] rtt_ticks;
    logic                ack_misaligned;
    logic                resend_valid;
    logic [31:0]         resend_seq;
    logic [15:0]         resend_length;
    logic [31:0]         next_seq;
  } res_t;

  typedef struct packed {
    logic        window_we;
    logic        base_we;
    logic        thresh_we;
    logic [31:0] wdata;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/tcp_send_window_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tcp_send_window_tracker_unit
// send window tracker: segment ring, cumulative acks, fast retransmit
// ----------------------------------------------------------------------------
// channel   direction  handshake
// request   in         push / full
// result    out        pop / empty
// config    in         apb psel/penable/pwrite, pready high
// send, dup ack, resend and behind-base acks are answered straight from the idle state
// an ack ahead of the base pops segments in S_POP, then answers from S_DONE (ring read port)
// a two-entry request queue keeps accepting while the back end works
// reset clears pointers, counts and registers; the ring needs no clearing
module tcp_send_window_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [31:0] seq_num_i,
  input  logic [15:0] seg_length_i,
  input  logic [31:0] ack_num_i,
  input  logic [tswt_pkg::TimeBits-1:0] now_ticks_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  send_status_o,
  output logic        new_ack_o,
  output logic        dup_ack_o,
  output logic        fast_retransmit_o,
  output logic        rtt_valid_o,
  output logic [tswt_pkg::TimeBits-1:0] rtt_ticks_o,
  output logic        ack_misaligned_o,
  output logic        resend_valid_o,
  output logic [31:0] resend_seq_o,
  output logic [15:0] resend_length_o,
  output logic [31:0] next_seq_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  tswt_pkg::req_t req_in, req_q;
  tswt_pkg::res_t res;
  tswt_pkg::cfg_t cfg;
  logic vld, take, res_vld, wr;
  logic [31:0] window, base_cfg;
  logic [7:0] thr_cfg;

  assign req_in = '{kind: kind_i, seq_num: seq_num_i, seg_length: seg_length_i,
                    ack_num: ack_num_i, now_ticks: now_ticks_i};

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg.window_we = wr && paddr[3:2] == tswt_pkg::RegWindow;
  assign cfg.base_we   = wr && paddr[3:2] == tswt_pkg::RegBase;
  assign cfg.thresh_we = wr && paddr[3:2] == tswt_pkg::RegThresh;
  assign cfg.wdata     = pwdata;

  always_comb begin
    case (paddr[3:2])
      tswt_pkg::RegWindow: prdata = window;
      tswt_pkg::RegBase:   prdata = base_cfg;
      tswt_pkg::RegThresh: prdata = {24'd0, thr_cfg};
      default:             prdata = 32'd0;
    endcase
  end

  tswt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i(req_in),
    .vld_o(vld), .take_i(take), .req_o(req_q)
  );

  tswt_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .vld_i(vld), .req_i(req_q), .take_o(take),
    .res_vld_o(res_vld), .pop_i(pop), .res_o(res), .window_o(window),
    .base_cfg_o(base_cfg), .thresh_cfg_o(thr_cfg)
  );

  assign empty             = !res_vld;
  assign send_status_o     = res.send_status;
  assign new_ack_o         = res.new_ack;
  assign dup_ack_o         = res.dup_ack;
  assign fast_retransmit_o = res.fast_retransmit;
  assign rtt_valid_o       = res.rtt_valid;
  assign rtt_ticks_o       = res.rtt_ticks;
  assign ack_misaligned_o  = res.ack_misaligned;
  assign resend_valid_o    = res.resend_valid;
  assign resend_seq_o      = res.resend_seq;
  assign resend_length_o   = res.resend_length;
  assign next_seq_o        = res.next_seq;

endmodule

// ===== rtl/core/tswt_front.sv =====
// ----------------------------------------------------------------------------
// tswt_front
// input queue between the request port and the execution back end
// ----------------------------------------------------------------------------
module tswt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  tswt_pkg::req_t  req_i,
  output logic            vld_o,
  input  logic            take_i,
  output tswt_pkg::req_t  req_o
);

  tswt_pkg::req_t mem_q [tswt_pkg::QDepth];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == 2'(tswt_pkg::QDepth));
  assign vld_o   = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && vld_o;
  assign req_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(tswt_pkg::QDepth)) else $error("queue overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count");
  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> rd_q == wr_q) else $error("pointers");
`endif

endmodule

// ===== rtl/core/tswt_back.sv =====
// ----------------------------------------------------------------------------
// tswt_back
// ring state and request execution, one popped segment per cycle
// ----------------------------------------------------------------------------
module tswt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tswt_pkg::cfg_t  cfg_i,
  input  logic            vld_i,
  input  tswt_pkg::req_t  req_i,
  output logic            take_o,
  output logic            res_vld_o,
  input  logic            pop_i,
  output tswt_pkg::res_t  res_o,
  output logic [31:0]     window_o,
  output logic [31:0]     base_cfg_o,
  output logic [7:0]      thresh_cfg_o
);
  localparam int PB = tswt_pkg::PtrBits;
  localparam int CB = tswt_pkg::CntBits;
  localparam int TB = tswt_pkg::TimeBits;

  logic [31:0] seq_mem [tswt_pkg::RingDepth];
  logic [15:0] len_mem [tswt_pkg::RingDepth];
  logic [TB-1:0] start_mem [tswt_pkg::RingDepth];

  tswt_pkg::state_e state_q, state_d;
  logic [PB-1:0] head_q, tail_q;
  logic [CB-1:0] count_q;
  logic [31:0] base_q, outst_q, window_q, base_cfg_q;
  logic [7:0] dupc_q, thr_q, thr_cfg_q;
  logic retx_q;
  tswt_pkg::res_t res_q;
  logic res_vld_q;
  tswt_pkg::req_t cur_q;
  logic popped_q;
  logic [TB-1:0] rtt_q;
  logic [31:0] oldnext_q;

  logic [31:0] hseq, nxt, room, ahead, d;
  logic [15:0] hlen;
  logic [TB-1:0] hstart;
  logic start, can_pop, out_free, send_ok;
  logic [8:0] tsum;

  assign hseq   = seq_mem[head_q];
  assign hlen   = len_mem[head_q];
  assign hstart = start_mem[head_q];
  assign nxt    = base_q + outst_q;
  assign room   = (window_q > outst_q) ? window_q - outst_q : 32'd0;
  assign out_free = !res_vld_q || pop_i;
  assign start  = (state_q == tswt_pkg::S_IDLE) && vld_i && out_free;
  assign take_o = start;
  assign ahead  = req_i.ack_num - base_q;
  assign d      = cur_q.ack_num - hseq;
  assign can_pop = (count_q != '0) && (d != 32'd0) && !d[31] && (d >= {16'd0, hlen});
  assign tsum   = {1'b0, thr_q} + {2'b0, thr_q[7:1]};
  assign send_ok = !(window_q != 32'd0 && room < {16'd0, req_i.seg_length}) &&
                   (req_i.seq_num == nxt) && (count_q != CB'(tswt_pkg::RingDepth));

  assign res_vld_o    = res_vld_q;
  assign res_o        = res_q;
  assign window_o     = window_q;
  assign base_cfg_o   = base_cfg_q;
  assign thresh_cfg_o = thr_cfg_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tswt_pkg::S_IDLE: begin
        if (start && req_i.kind == tswt_pkg::KindAck && ahead != 0 && !ahead[31])
          state_d = tswt_pkg::S_POP;
      end
      tswt_pkg::S_POP: begin
        if (!can_pop) state_d = tswt_pkg::S_DONE;
      end
      tswt_pkg::S_DONE: begin
        if (out_free) state_d = tswt_pkg::S_IDLE;
      end
      default: state_d = tswt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start && req_i.kind == tswt_pkg::KindSend && send_ok) begin
      seq_mem[tail_q]   <= req_i.seq_num;
      len_mem[tail_q]   <= req_i.seg_length;
      start_mem[tail_q] <= req_i.now_ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tswt_pkg::S_IDLE;
      head_q <= '0; tail_q <= '0; count_q <= '0;
      base_q <= '0; outst_q <= '0; window_q <= 32'd65535; base_cfg_q <= '0;
      dupc_q <= '0; thr_q <= 8'd3; thr_cfg_q <= 8'd3; retx_q <= 1'b0;
      res_vld_q <= 1'b0; res_q <= '0; cur_q <= '0;
      popped_q <= 1'b0; rtt_q <= '0; oldnext_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.window_we) window_q <= cfg_i.wdata;
      if (cfg_i.base_we) begin
        base_cfg_q <= cfg_i.wdata; base_q <= cfg_i.wdata;
      end
      if (cfg_i.thresh_we) thr_cfg_q <= cfg_i.wdata[7:0];
      if (pop_i && res_vld_q) res_vld_q <= 1'b0;
      if (start) begin
        res_q <= '0;
        case (req_i.kind)
          tswt_pkg::KindSend: begin
            if (window_q != 0 && room < {16'd0, req_i.seg_length}) begin
              res_q.send_status <= tswt_pkg::StNoRoom; res_q.next_seq <= nxt;
            end else if (req_i.seq_num != nxt) begin
              res_q.send_status <= tswt_pkg::StSeqErr; res_q.next_seq <= nxt;
            end else if (count_q == CB'(tswt_pkg::RingDepth)) begin
              res_q.send_status <= tswt_pkg::StFull; res_q.next_seq <= nxt;
            end else begin
              res_q.send_status <= tswt_pkg::StOk;
              tail_q <= tail_q + 1'b1;
              count_q <= count_q + 1'b1;
              outst_q <= outst_q + {16'd0, req_i.seg_length};
              res_q.next_seq <= nxt + {16'd0, req_i.seg_length};
            end
            res_vld_q <= 1'b1;
          end
          tswt_pkg::KindAck: begin
            if (ahead != 0 && !ahead[31]) begin
              cur_q <= req_i; popped_q <= 1'b0; rtt_q <= '0; oldnext_q <= nxt;
            end else begin
              if (ahead == 0) begin
                res_q.dup_ack <= 1'b1;
                if ((dupc_q == 8'd255 ? dupc_q : dupc_q + 8'd1) >= thr_q) begin
                  dupc_q <= '0;
                  thr_q <= tsum[8] ? 8'd255 : tsum[7:0];
                  res_q.fast_retransmit <= 1'b1;
                end else if (dupc_q != 8'd255) begin
                  dupc_q <= dupc_q + 8'd1;
                end
              end
              res_q.next_seq <= nxt;
              res_vld_q <= 1'b1;
            end
          end
          tswt_pkg::KindResend: begin
            if (count_q != '0) begin
              retx_q <= 1'b1;
              res_q.resend_valid <= 1'b1;
              res_q.resend_seq <= hseq;
              res_q.resend_length <= hlen;
            end
            res_q.next_seq <= nxt;
            res_vld_q <= 1'b1;
          end
          default: begin
            res_q.next_seq <= nxt;
            res_vld_q <= 1'b1;
          end
        endcase
      end
      if (state_q == tswt_pkg::S_POP && can_pop) begin
        outst_q <= outst_q - {16'd0, hlen};
        rtt_q <= cur_q.now_ticks - hstart;
        popped_q <= 1'b1;
        head_q <= head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (state_q == tswt_pkg::S_DONE && out_free) begin
        res_q <= '0;
        res_q.new_ack <= 1'b1;
        res_q.ack_misaligned <=
          cur_q.ack_num != ((count_q != '0) ? hseq : oldnext_q);
        res_q.rtt_valid <= popped_q && !retx_q;
        res_q.rtt_ticks <= (popped_q && !retx_q) ? rtt_q : '0;
        res_q.next_seq <= cur_q.ack_num + outst_q;
        res_vld_q <= 1'b1;
        base_q <= cur_q.ack_num;
        dupc_q <= '0;
        thr_q <= thr_cfg_q;
        if (count_q == '0) retx_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CB'(tswt_pkg::RingDepth)) else $error("ring count");
  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> head_q == tail_q) else $error("ring pointers");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> state_q == tswt_pkg::S_IDLE) else $error("take while busy");
`endif

endmodule
